/* rtl/bitmap_slot_allocator_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap slot allocator
// Clocked on clk; the disabled forms drop checks while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// consequent in the next cycle, checked outside reset
`define BSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap slot allocator check failed");

// consequent in the next cycle, checked during reset as well
`define BSA_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bitmap slot allocator reset check failed");

`endif

/* rtl/bsa_pkg.sv */
// ---------------------------------------------------------------------------
// bsa_pkg
// Sizes, codes and helpers shared by the bitmap slot allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int unsigned SLOT_COUNT = 4096;
  localparam int unsigned WORD_BITS  = 8;
  localparam int unsigned WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned FILL_W     = $clog2(WORD_COUNT + 1);
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned STAT_W     = 2;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DONE
  } bsa_state_t;

  typedef logic [WORD_BITS-1:0] bsa_word_t;

  function automatic logic [BIT_W-1:0] lowest_clear(input bsa_word_t w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* rtl/bitmap_slot_allocator_core.sv */
// Flow: a release reads its word in S_CHECK, then S_DONE loads the result into out_tdata;
// an out-of-range release goes straight to S_DONE; an allocate scans 1 to 512 bitmap words in S_CHECK.
// One transaction at a time: the next accept follows once the result loads into the
// output register, which an out_tready stall can hold back.
// Reset: synchronous; bitmap reads as all free through a word fill count,
// no clearing pass, so in_tready is high as soon as reset is released.
// ---------------------------------------------------------------------------
// bitmap_slot_allocator_core
// First-fit slot allocator over a bitmap of used slots kept in RAM words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_slot_allocator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bsa_pkg::IDX_W-1:0]   cfg_wr_data,   // highest_index
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,      // [11:0] slot_index
  input  logic                        in_tuser,      // [0] kind
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata      // [11:0] granted_index, [13:12] status
);

  localparam int unsigned AW = bsa_pkg::ADDR_W;
  localparam int unsigned BW = bsa_pkg::BIT_W;
  localparam int unsigned IW = bsa_pkg::IDX_W;
  localparam int unsigned SW = bsa_pkg::STAT_W;

  bsa_pkg::bsa_state_t state_r, state_nxt;

  logic [IW-1:0]                  hi_r;
  logic [bsa_pkg::FILL_W-1:0]     fill_r;
  logic                           kind_r, kind_nxt;
  logic [AW-1:0]                  word_r, word_nxt;
  logic [BW-1:0]                  bit_r, bit_nxt;
  logic [IW-1:0]                  res_idx_r, res_idx_nxt;
  logic [SW-1:0]                  res_st_r, res_st_nxt;
  logic                           out_valid_r;
  logic [IW-1:0]                  out_idx_r;
  logic [SW-1:0]                  out_st_r;

  logic                           in_fire;
  logic                           out_load;
  logic [IW-1:0]                  in_slot;
  logic [IW-1:0]                  limit;
  logic [AW-1:0]                  limit_word;
  bsa_pkg::bsa_word_t             rd_data;
  bsa_pkg::bsa_word_t             cur_word;
  logic                           word_valid;
  logic                           word_full;
  logic [BW-1:0]                  free_bit;
  logic [AW+BW-1:0]               cand_slot;
  logic                           alloc_hit;
  logic                           scan_end;
  logic                           bad_release;
  logic                           wr_en;
  bsa_pkg::bsa_word_t             wr_data;

  assign in_tready = (state_r == bsa_pkg::S_IDLE) && rst_n;
  assign in_fire   = in_tvalid && in_tready;
  assign in_slot   = in_tdata[IW-1:0];
  assign out_load  = (state_r == bsa_pkg::S_DONE) && (!out_valid_r || out_tready);

  assign limit = (32'(hi_r) >= bsa_pkg::SLOT_COUNT) ? IW'(bsa_pkg::SLOT_COUNT - 1) : hi_r;
  assign limit_word = AW'(limit >> BW);

  assign word_valid  = 32'(word_r) < 32'(fill_r);
  assign cur_word    = word_valid ? rd_data : '0;
  assign word_full   = &cur_word;
  assign free_bit    = bsa_pkg::lowest_clear(cur_word);
  assign cand_slot   = {word_r, free_bit};
  assign alloc_hit   = !word_full && (32'(cand_slot) <= 32'(limit));
  assign scan_end    = !word_full || (word_r == limit_word);
  assign bad_release = in_slot > limit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsa_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tuser == bsa_pkg::KIND_RELEASE && bad_release) ?
                      bsa_pkg::S_DONE : bsa_pkg::S_CHECK;
        end
      end
      bsa_pkg::S_CHECK: begin
        if (kind_r == bsa_pkg::KIND_RELEASE || alloc_hit || scan_end) begin
          state_nxt = bsa_pkg::S_DONE;
        end
      end
      bsa_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = bsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt    = kind_r;
    word_nxt    = word_r;
    bit_nxt     = bit_r;
    res_idx_nxt = res_idx_r;
    res_st_nxt  = res_st_r;
    wr_en       = 1'b0;
    wr_data     = cur_word;
    unique case (state_r)
      bsa_pkg::S_IDLE: begin
        if (in_fire) begin
          kind_nxt    = in_tuser;
          word_nxt    = (in_tuser == bsa_pkg::KIND_ALLOC) ? '0 : AW'(in_slot >> BW);
          bit_nxt     = BW'(in_slot);
          res_idx_nxt = '0;
          res_st_nxt  = (in_tuser == bsa_pkg::KIND_RELEASE && bad_release) ?
                        bsa_pkg::STAT_BAD_INDEX : bsa_pkg::STAT_OK;
        end
      end
      bsa_pkg::S_CHECK: begin
        if (kind_r == bsa_pkg::KIND_RELEASE) begin
          wr_en   = word_valid;
          wr_data = cur_word & ~(bsa_pkg::bsa_word_t'(1) << bit_r);
        end else if (alloc_hit) begin
          wr_en       = 1'b1;
          wr_data     = cur_word | (bsa_pkg::bsa_word_t'(1) << free_bit);
          res_idx_nxt = IW'(cand_slot);
        end else if (scan_end) begin
          res_st_nxt = bsa_pkg::STAT_FULL;
        end else begin
          word_nxt = word_r + AW'(1);
        end
      end
      bsa_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  bsa_ram #(
    .WIDTH (bsa_pkg::WORD_BITS),
    .DEPTH (bsa_pkg::WORD_COUNT)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (word_r),
    .wr_data (wr_data),
    .rd_addr (word_nxt),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsa_pkg::S_IDLE;
      hi_r        <= IW'(bsa_pkg::SLOT_COUNT - 1);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        hi_r <= cfg_wr_data;
      end
      if (wr_en && (32'(fill_r) == 32'(word_r)) && (32'(fill_r) < bsa_pkg::WORD_COUNT)) begin
        fill_r <= fill_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    word_r    <= word_nxt;
    bit_r     <= bit_nxt;
    res_idx_r <= res_idx_nxt;
    res_st_r  <= res_st_nxt;
    if (out_load) begin
      out_idx_r <= res_idx_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_st_r, out_idx_r};

endmodule

/* rtl/bsa_ram.sv */
// ---------------------------------------------------------------------------
// bsa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/bsa_checker.sv */
// ---------------------------------------------------------------------------
// bsa_checker
// Port-level checks on the bitmap slot allocator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bitmap_slot_allocator_core_assert.svh"

module bsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  `BSA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `BSA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BSA_ASSERT_NEXT_ALWAYS(a_reset_clears_out, !rst_n, !out_tvalid)

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata)
);

/* test/bitmap_slot_allocator_core_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitmap_slot_allocator_core_test
// Streams allocate and release transactions into the allocator under random
// source gaps and sink stalls, predicts each result from a local first-fit
// bitmap and compares granted index and status in order. The highest index
// is rewritten between phases, from zero to the full range.
// ---------------------------------------------------------------------------

module bitmap_slot_allocator_core_test;

  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic                       kind;
    logic [bsa_pkg::IDX_W-1:0]  slot;
  } request_t;

  typedef struct packed {
    logic [bsa_pkg::IDX_W-1:0]  granted;
    logic [bsa_pkg::STAT_W-1:0] status;
  } outcome_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [bsa_pkg::IDX_W-1:0]  cfg_wr_data = '0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [15:0]                in_tdata = '0;   // [11:0] slot_index
  logic                       in_tuser = 1'b0; // [0] kind
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [15:0]                out_tdata;       // [11:0] granted_index, [13:12] status

  bitmap_slot_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bsa_pkg::bsa_word_t        slot_map [bsa_pkg::WORD_COUNT];
  logic [bsa_pkg::IDX_W-1:0] limit_now = 12'hFFF;
  request_t                  pending [$];
  outcome_t                  awaited [$];
  int                        queued_count = 0;
  int                        done_count = 0;
  int                        mismatches = 0;
  int                        idle_odds = 6;
  int                        send_gap = 0;
  int                        hold_left = 0;
  int                        quiet_cycles = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] result %0d: %s", $realtime, done_count, what);
  endtask

  // first-fit allocate or release against the local bitmap
  function automatic outcome_t serve_request(input logic kind,
                                             input logic [bsa_pkg::IDX_W-1:0] slot);
    outcome_t o;
    int       top;
    bit       found;
    o = '0;
    found = 1'b0;
    top = (int'(limit_now) >= int'(bsa_pkg::SLOT_COUNT)) ?
          int'(bsa_pkg::SLOT_COUNT) - 1 : int'(limit_now);
    if (kind == bsa_pkg::KIND_ALLOC) begin
      for (int s = 0; s <= top && !found; s++) begin
        if (!slot_map[s / bsa_pkg::WORD_BITS][s % bsa_pkg::WORD_BITS]) begin
          slot_map[s / bsa_pkg::WORD_BITS][s % bsa_pkg::WORD_BITS] = 1'b1;
          o.granted = bsa_pkg::IDX_W'(s);
          found = 1'b1;
        end
      end
      o.status = found ? bsa_pkg::STAT_OK : bsa_pkg::STAT_FULL;
    end else if (int'(slot) > top) begin
      o.status = bsa_pkg::STAT_BAD_INDEX;
    end else begin
      slot_map[slot / bsa_pkg::WORD_BITS][slot % bsa_pkg::WORD_BITS] = 1'b0;
      o.status = bsa_pkg::STAT_OK;
    end
    return o;
  endfunction

  // driver: predict on accept, then present the next transaction or a gap
  always @(posedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      for (int w = 0; w < bsa_pkg::WORD_COUNT; w++) begin
        slot_map[w] = '0;
      end
      limit_now = 12'hFFF;
      send_gap = 0;
    end else begin
      if (cfg_wr_en) begin
        limit_now = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        awaited.push_back(serve_request(in_tuser, in_tdata[bsa_pkg::IDX_W-1:0]));
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          nxt = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.kind;
          in_tdata <= {4'b0, nxt.slot};
          if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            send_gap = $urandom_range(1, 9);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result against the oldest prediction, stall at random
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata=%h", out_tdata));
        end else begin
          want = awaited.pop_front();
          if (out_tdata[bsa_pkg::IDX_W-1:0] !== want.granted) begin
            report_mismatch($sformatf("granted_index %0d, want %0d",
                                      out_tdata[bsa_pkg::IDX_W-1:0], want.granted));
          end
          if (out_tdata[bsa_pkg::IDX_W+bsa_pkg::STAT_W-1:bsa_pkg::IDX_W] !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d",
                            out_tdata[bsa_pkg::IDX_W+bsa_pkg::STAT_W-1:bsa_pkg::IDX_W],
                            want.status));
          end
        end
        done_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        hold_left = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_request(input logic kind, input int slot);
    request_t r;
    r.kind = kind;
    r.slot = bsa_pkg::IDX_W'(slot);
    pending.push_back(r);
    queued_count++;
  endtask

  task automatic wait_drained();
    while (done_count != queued_count) begin
      @(negedge clk);
    end
  endtask

  task automatic set_limit(input int value);
    wait_drained();
    repeat (6) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= bsa_pkg::IDX_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int lim;
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset limit: basic grants, release of a free slot, top index
    push_request(bsa_pkg::KIND_ALLOC, 0);
    push_request(bsa_pkg::KIND_ALLOC, 4095);
    push_request(bsa_pkg::KIND_ALLOC, 0);
    push_request(bsa_pkg::KIND_RELEASE, 1);
    push_request(bsa_pkg::KIND_ALLOC, 0);
    push_request(bsa_pkg::KIND_RELEASE, 4095);
    push_request(bsa_pkg::KIND_RELEASE, 0);
    push_request(bsa_pkg::KIND_ALLOC, 0);

    // limit zero: full, release above the limit
    set_limit(0);
    push_request(bsa_pkg::KIND_ALLOC, 0);
    push_request(bsa_pkg::KIND_RELEASE, 1);
    push_request(bsa_pkg::KIND_RELEASE, 4095);
    push_request(bsa_pkg::KIND_RELEASE, 0);
    push_request(bsa_pkg::KIND_ALLOC, 0);
    push_request(bsa_pkg::KIND_ALLOC, 0);

    // limit across a word boundary
    set_limit(12);
    repeat (11) push_request(bsa_pkg::KIND_ALLOC, 0);
    push_request(bsa_pkg::KIND_RELEASE, 8);
    push_request(bsa_pkg::KIND_ALLOC, 0);

    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 4))
        0: lim = $urandom_range(0, 7);
        1: lim = $urandom_range(8, 40);
        2: lim = $urandom_range(41, 300);
        3: lim = 4095;
        default: lim = $urandom_range(300, 4094);
      endcase
      set_limit(lim);
      case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 3;
        default: idle_odds = 8;
      endcase
      repeat (60) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          push_request(bsa_pkg::KIND_ALLOC, $urandom_range(0, 4095));
        end else if (pick < 75) begin
          push_request(bsa_pkg::KIND_RELEASE, $urandom_range(0, (lim < 63) ? lim : 63));
        end else if (pick < 90) begin
          push_request(bsa_pkg::KIND_RELEASE, $urandom_range(0, lim));
        end else begin
          push_request(bsa_pkg::KIND_RELEASE, $urandom_range(0, 4095));
        end
      end
    end

    // fill deep into the bitmap at the full limit
    set_limit(4095);
    idle_odds = 6;
    repeat (1000) begin
      if ($urandom_range(0, 19) == 0) begin
        push_request(bsa_pkg::KIND_RELEASE, $urandom_range(0, 1023));
      end else begin
        push_request(bsa_pkg::KIND_ALLOC, $urandom_range(0, 4095));
      end
    end

    // limit below the filled region, no idling
    lim = $urandom_range(400, 700);
    set_limit(lim);
    idle_odds = 0;
    repeat (60) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        push_request(bsa_pkg::KIND_ALLOC, $urandom_range(0, 4095));
      end else if (pick < 7) begin
        push_request(bsa_pkg::KIND_RELEASE, $urandom_range(0, lim));
      end else begin
        push_request(bsa_pkg::KIND_RELEASE, $urandom_range(lim + 1, 4095));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (awaited.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived", awaited.size()));
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bsa_pkg.sv
rtl/bsa_ram.sv
rtl/bitmap_slot_allocator_core.sv
rtl/bsa_checker.sv
test/bitmap_slot_allocator_core_test.sv
